### design/ps2dt_pkg.sv
// Package for the PS/2 device-side transceiver.
// Holds the item structs, phase and bus codes and the configuration constants.
// No dependencies.
`default_nettype none

package ps2dt_pkg;

  localparam int unsigned TICK_BITS_DEFAULT = 20;
  localparam int unsigned QUARTER_W         = 16;
  localparam int unsigned GAP_W             = 20;
  localparam int unsigned CFG_IDX_W         = 2;
  localparam int unsigned CFG_DATA_W        = 20;

  localparam logic [31:0] QUARTER_RESET = 32'd1000;
  localparam logic [31:0] GAP_RESET     = 32'd25000;

  // Frame bit positions: start, data 1..8, parity, stop/ack.
  localparam logic [3:0] BIT_FIRST_DATA = 4'd1;
  localparam logic [3:0] BIT_LAST_DATA  = 4'd8;
  localparam logic [3:0] BIT_PARITY     = 4'd9;
  localparam logic [3:0] BIT_LAST       = 4'd10;

  localparam logic [1:0] QUARTER_LAST = 2'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_QUARTER = 2'd0,
    CFG_GAP     = 2'd1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    BUS_IDLE    = 2'd0,
    BUS_INHIBIT = 2'd1,
    BUS_RTS     = 2'd2
  } bus_e;

  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_GAP  = 4'b0010,
    PH_TX   = 4'b0100,
    PH_RX   = 4'b1000
  } phase_e;

  typedef struct packed {
    logic       clk_line;
    logic       data_line;
    logic       tx_valid;
    logic [7:0] tx_byte;
  } in_item_t;

  typedef struct packed {
    logic       clk_drive_low;
    logic       data_drive_low;
    bus_e       bus_state;
    logic       busy_res;
    logic       tx_done;
    logic       tx_rejected;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic       rx_parity_ok;
  } res_item_t;

endpackage

`default_nettype wire

### design/ps2_device_transceiver_core.sv
// Top level of the PS/2 device-side transceiver: input register, frame engine,
// result register and configuration registers. Depends on ps2dt_pkg,
// ps2dt_cfg and ps2dt_engine.
//
//   channel   direction  handshake               payload
//   in        input      in_valid_i/in_ready_o    clk_line, data_line, tx_valid, tx_byte
//   out       output     out_valid_o/out_ready_i  drives, bus_state, status pulses, rx byte
//   cfg       input      cfg_we_i                 cfg_idx_i, cfg_wdata_i
//
// One item is taken every clock unless the result side stalls; each item gives
// one result: input register, then the engine step into the result register.
// The engine step is one pass of narrow counter compares and selects.
// A stalled result holds the result register, the input register and the
// engine state; in_ready_o drops only once the input register is also full.
// Reset puts the engine idle and loads the default quarter period and byte gap.
`default_nettype none

module ps2_device_transceiver_core #(
  parameter int unsigned TICK_COUNTER_BITS = ps2dt_pkg::TICK_BITS_DEFAULT
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire logic                             clk_line_i,
  input  wire logic                             data_line_i,
  input  wire logic                             tx_valid_i,
  input  wire logic [7:0]                       tx_byte_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output logic                                  clk_drive_low_o,
  output logic                                  data_drive_low_o,
  output logic      [1:0]                       bus_state_o,
  output logic                                  busy_res_o,
  output logic                                  tx_done_o,
  output logic                                  tx_rejected_o,
  output logic                                  rx_valid_o,
  output logic      [7:0]                       rx_byte_o,
  output logic                                  rx_parity_ok_o,
  input  wire logic                             cfg_we_i,
  input  wire logic [ps2dt_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [ps2dt_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import ps2dt_pkg::*;

  logic      in_valid_q;
  in_item_t  in_item_q;
  logic      out_valid_q;
  res_item_t res_q;
  res_item_t res_d;
  logic      advance;

  logic [TICK_COUNTER_BITS-1:0] quarter_lim;
  logic [TICK_COUNTER_BITS-1:0] gap_lim;

  // The engine steps when the input register holds an item and the result
  // register is free or being emptied in this cycle.
  assign advance    = !out_valid_q || out_ready_i;
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_item_q.clk_line  <= clk_line_i;
      in_item_q.data_line <= data_line_i;
      in_item_q.tx_valid  <= tx_valid_i;
      in_item_q.tx_byte   <= tx_byte_i;
    end
    if (advance && in_valid_q) begin
      res_q <= res_d;
    end
  end

  ps2dt_cfg #(
    .TICK_COUNTER_BITS(TICK_COUNTER_BITS)
  ) u_cfg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .quarter_lim_o (quarter_lim),
    .gap_lim_o     (gap_lim)
  );

  ps2dt_engine #(
    .TICK_COUNTER_BITS(TICK_COUNTER_BITS)
  ) u_engine (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (advance && in_valid_q),
    .item_i        (in_item_q),
    .quarter_lim_i (quarter_lim),
    .gap_lim_i     (gap_lim),
    .res_o         (res_d)
  );

  assign out_valid_o      = out_valid_q;
  assign clk_drive_low_o  = res_q.clk_drive_low;
  assign data_drive_low_o = res_q.data_drive_low;
  assign bus_state_o      = res_q.bus_state;
  assign busy_res_o       = res_q.busy_res;
  assign tx_done_o        = res_q.tx_done;
  assign tx_rejected_o    = res_q.tx_rejected;
  assign rx_valid_o       = res_q.rx_valid;
  assign rx_byte_o        = res_q.rx_byte;
  assign rx_parity_ok_o   = res_q.rx_parity_ok;

endmodule

`default_nettype wire

### design/ps2dt_cfg.sv
// Configuration registers of the PS/2 transceiver.
// Stores the quarter period and byte gap already clamped to the tick counter range.
// Depends on ps2dt_pkg.
`default_nettype none

module ps2dt_cfg #(
  parameter int unsigned TICK_COUNTER_BITS = ps2dt_pkg::TICK_BITS_DEFAULT
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cfg_we_i,
  input  wire logic [ps2dt_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire logic [ps2dt_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  output logic      [TICK_COUNTER_BITS-1:0]         quarter_lim_o,
  output logic      [TICK_COUNTER_BITS-1:0]         gap_lim_o
);
  import ps2dt_pkg::*;

  localparam int unsigned CW = TICK_COUNTER_BITS;

  // Clamp to the largest counter value; the quarter period never drops below one.
  function automatic logic [CW-1:0] sat_lim(input logic [31:0] v, input logic min_one);
    logic [32:0] m;
    logic [32:0] r;
    m = (33'd1 << CW) - 33'd1;
    r = ({1'b0, v} > m) ? m : {1'b0, v};
    if (min_one && (r == 33'd0)) begin
      r = 33'd1;
    end
    return r[CW-1:0];
  endfunction

  localparam logic [CW-1:0] QUARTER_LIM_RST = sat_lim(QUARTER_RESET, 1'b1);
  localparam logic [CW-1:0] GAP_LIM_RST     = sat_lim(GAP_RESET, 1'b0);

  logic [CW-1:0] quarter_lim_q, quarter_lim_d;
  logic [CW-1:0] gap_lim_q, gap_lim_d;

  always_comb begin
    quarter_lim_d = quarter_lim_q;
    gap_lim_d     = gap_lim_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_QUARTER: quarter_lim_d = sat_lim(32'(cfg_wdata_i[QUARTER_W-1:0]), 1'b1);
        CFG_GAP:     gap_lim_d     = sat_lim(32'(cfg_wdata_i[GAP_W-1:0]), 1'b0);
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quarter_lim_q <= QUARTER_LIM_RST;
      gap_lim_q     <= GAP_LIM_RST;
    end else begin
      quarter_lim_q <= quarter_lim_d;
      gap_lim_q     <= gap_lim_d;
    end
  end

  assign quarter_lim_o = quarter_lim_q;
  assign gap_lim_o     = gap_lim_q;

endmodule

`default_nettype wire

### design/ps2dt_engine.sv
// Frame engine of the PS/2 transceiver: phase, bit timing and shift state.
// Advances one tick per step and forms that tick's result item.
// Depends on ps2dt_pkg.
`default_nettype none

module ps2dt_engine #(
  parameter int unsigned TICK_COUNTER_BITS = ps2dt_pkg::TICK_BITS_DEFAULT
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          step_i,
  input  wire ps2dt_pkg::in_item_t           item_i,
  input  wire logic [TICK_COUNTER_BITS-1:0]  quarter_lim_i,
  input  wire logic [TICK_COUNTER_BITS-1:0]  gap_lim_i,
  output ps2dt_pkg::res_item_t               res_o
);
  import ps2dt_pkg::*;

  localparam int unsigned CW = TICK_COUNTER_BITS;

  phase_e        phase_q, phase_d;
  logic [CW-1:0] tick_q, tick_d;
  logic [1:0]    quarter_q, quarter_d;
  logic [3:0]    bit_q, bit_d;
  logic [7:0]    shift_q, shift_d;
  logic          par_acc_q, par_acc_d;
  logic          par_seen_q, par_seen_d;

  bus_e    bus;
  logic    clk_low_quarter;
  logic    quarter_tick_end;
  logic    gap_end;
  logic    bit_end;
  logic    data_bit;
  logic    tx_level;
  logic [CW:0] tick_inc;

  always_comb begin
    if (!item_i.clk_line) begin
      bus = BUS_INHIBIT;
    end else if (!item_i.data_line) begin
      bus = BUS_RTS;
    end else begin
      bus = BUS_IDLE;
    end
  end

  assign tick_inc         = {1'b0, tick_q} + {{CW{1'b0}}, 1'b1};
  assign quarter_tick_end = tick_inc >= {1'b0, quarter_lim_i};
  assign gap_end          = tick_inc >= {1'b0, gap_lim_i};
  assign bit_end          = quarter_tick_end && (quarter_q == QUARTER_LAST);
  assign clk_low_quarter  = (quarter_q == 2'd1) || (quarter_q == 2'd2);
  assign data_bit         = (bit_q >= BIT_FIRST_DATA) && (bit_q <= BIT_LAST_DATA);

  always_comb begin
    if (bit_q == 4'd0) begin
      tx_level = 1'b0;
    end else if (bit_q <= BIT_LAST_DATA) begin
      tx_level = shift_q[0];
    end else if (bit_q == BIT_PARITY) begin
      tx_level = par_acc_q;
    end else begin
      tx_level = 1'b1;
    end
  end

  always_comb begin
    phase_d    = phase_q;
    tick_d     = tick_q;
    quarter_d  = quarter_q;
    bit_d      = bit_q;
    shift_d    = shift_q;
    par_acc_d  = par_acc_q;
    par_seen_d = par_seen_q;

    res_o                = '0;
    res_o.bus_state      = bus;
    res_o.busy_res       = (phase_q != PH_IDLE);
    res_o.tx_rejected    = item_i.tx_valid && ((phase_q != PH_IDLE) || (bus != BUS_IDLE));

    // Shared bit timer for transmit and receive frames.
    if ((phase_q == PH_TX) || (phase_q == PH_RX)) begin
      if (quarter_tick_end) begin
        tick_d    = '0;
        quarter_d = bit_end ? 2'd0 : quarter_q + 2'd1;
      end else begin
        tick_d = tick_inc[CW-1:0];
      end
    end

    case (phase_q)
      PH_IDLE: begin
        if (item_i.tx_valid && (bus == BUS_IDLE)) begin
          shift_d   = item_i.tx_byte;
          par_acc_d = 1'b1;
          tick_d    = '0;
          quarter_d = 2'd0;
          bit_d     = 4'd0;
          phase_d   = (gap_lim_i == '0) ? PH_TX : PH_GAP;
        end else if (bus == BUS_RTS) begin
          shift_d    = 8'd0;
          par_acc_d  = 1'b1;
          par_seen_d = 1'b0;
          tick_d     = '0;
          quarter_d  = 2'd0;
          bit_d      = 4'd0;
          phase_d    = PH_RX;
        end
      end
      PH_GAP: begin
        if (gap_end) begin
          tick_d    = '0;
          quarter_d = 2'd0;
          bit_d     = 4'd0;
          phase_d   = PH_TX;
        end else begin
          tick_d = tick_inc[CW-1:0];
        end
      end
      PH_TX: begin
        res_o.clk_drive_low  = clk_low_quarter;
        res_o.data_drive_low = ~tx_level;
        if (bit_end) begin
          if (data_bit) begin
            par_acc_d = par_acc_q ^ shift_q[0];
            shift_d   = {1'b0, shift_q[7:1]};
          end
          if (bit_q >= BIT_LAST) begin
            res_o.tx_done = 1'b1;
            bit_d         = 4'd0;
            phase_d       = PH_IDLE;
          end else begin
            bit_d = bit_q + 4'd1;
          end
        end
      end
      PH_RX: begin
        res_o.clk_drive_low  = clk_low_quarter;
        res_o.data_drive_low = (bit_q == BIT_LAST) && (quarter_q != 2'd0);
        // The host's data is sampled at the very start of each bit, before the clock is driven low.
        if ((quarter_q == 2'd0) && (tick_q == '0)) begin
          if (data_bit) begin
            shift_d   = {item_i.data_line, shift_q[7:1]};
            par_acc_d = par_acc_q ^ item_i.data_line;
          end else if (bit_q == BIT_PARITY) begin
            par_seen_d = item_i.data_line;
          end
        end
        if (bit_end) begin
          if (bit_q >= BIT_LAST) begin
            res_o.rx_valid     = 1'b1;
            res_o.rx_byte      = shift_q;
            res_o.rx_parity_ok = (par_seen_q == par_acc_q);
            bit_d              = 4'd0;
            phase_d            = PH_IDLE;
          end else begin
            bit_d = bit_q + 4'd1;
          end
        end
      end
      default: begin
        phase_d = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      tick_q     <= '0;
      quarter_q  <= 2'd0;
      bit_q      <= 4'd0;
      shift_q    <= 8'd0;
      par_acc_q  <= 1'b1;
      par_seen_q <= 1'b0;
    end else if (step_i) begin
      phase_q    <= phase_d;
      tick_q     <= tick_d;
      quarter_q  <= quarter_d;
      bit_q      <= bit_d;
      shift_q    <= shift_d;
      par_acc_q  <= par_acc_d;
      par_seen_q <= par_seen_d;
    end
  end

endmodule

`default_nettype wire

### design/ps2dt_checker.sv
// Port-level checks for the PS/2 transceiver core, bound to its top level.
// Depends only on the port list of ps2_device_transceiver_core.
`default_nettype none

module ps2dt_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_o,
  input wire logic       out_ready_i,
  input wire logic       clk_drive_low_o,
  input wire logic       data_drive_low_o,
  input wire logic       busy_res_o,
  input wire logic       tx_done_o,
  input wire logic       rx_valid_o,
  input wire logic [7:0] rx_byte_o,
  input wire logic       rx_parity_ok_o
);

  // A result waiting to be taken holds still.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(rx_byte_o) &&
      $stable(rx_valid_o) && $stable(tx_done_o))
    else $error("result item changed while stalled");

  // The received byte and parity flag read zero outside a receive report.
  a_rx_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !rx_valid_o |-> (rx_byte_o == 8'd0) && !rx_parity_ok_o)
    else $error("rx fields nonzero without rx_valid");

  // A transmit and a receive frame never end on the same tick.
  a_one_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(tx_done_o && rx_valid_o))
    else $error("tx_done and rx_valid together");

  // The lines are only driven, and frames only end, while the block is busy.
  a_drive_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (clk_drive_low_o || data_drive_low_o || tx_done_o || rx_valid_o)
      |-> busy_res_o)
    else $error("line driven or frame ended while not busy");

endmodule

bind ps2_device_transceiver_core ps2dt_checker u_ps2dt_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .clk_drive_low_o  (clk_drive_low_o),
  .data_drive_low_o (data_drive_low_o),
  .busy_res_o       (busy_res_o),
  .tx_done_o        (tx_done_o),
  .rx_valid_o       (rx_valid_o),
  .rx_byte_o        (rx_byte_o),
  .rx_parity_ok_o   (rx_parity_ok_o)
);

`default_nettype wire
